[rtl/pfdp_pkg.sv]
// Shared types, constants and tables for the pixel fog, dither and pack pipeline.
package pfdp_pkg;

    // Pipeline stage numbers
    localparam int ST_IN    = 0;
    localparam int ST_MAG   = 1;
    localparam int ST_MUL   = 2;
    localparam int ST_RECIP = 3;
    localparam int ST_FABS  = 4;
    localparam int ST_UMAG  = 5;
    localparam int ST_DEC   = 6;
    localparam int ST_ARG   = 7;
    localparam int ST_E1    = 8;
    localparam int ST_FOG   = 9;
    localparam int ST_PROD  = 10;
    localparam int ST_SUM   = 11;
    localparam int ST_V     = 12;
    localparam int ST_LVL   = 13;
    localparam int ST_OUT   = 14;
    localparam int NST      = ST_OUT + 1;

    localparam int COORD_WIDTH_DEF = 12;
    localparam logic [15:0] UNIT = 16'd32768;

    // Fog modes
    localparam logic [1:0] FOG_NONE   = 2'd0;
    localparam logic [1:0] FOG_LINEAR = 2'd1;
    localparam logic [1:0] FOG_EXP    = 2'd2;
    localparam logic [1:0] FOG_EXP2   = 2'd3;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_FOG_MODE     = 3'd0,
        CFG_FOG_DENSITY  = 3'd1,
        CFG_FOG_START    = 3'd2,
        CFG_FAR_DEPTH    = 3'd3,
        CFG_INV_RANGE    = 3'd4,
        CFG_FOG_RGB      = 3'd5,
        CFG_COLOR_LEVELS = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]  fog_mode;
        logic [15:0] fog_density;
        logic [31:0] fog_start;
        logic [31:0] far_depth;
        logic [31:0] inv_depth_range;
        logic [47:0] fog_rgb;
        logic [8:0]  color_levels;
    } t_cfg;

    // Dither settings derived from color_levels
    typedef struct packed {
        logic [8:0]  lv;
        logic [18:0] mn;
        logic [8:0]  div;
        logic [18:0] mdiv;
    } t_dith;

    typedef struct packed {
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic [15:0] red_in;
        logic [15:0] green_in;
        logic [15:0] blue_in;
        logic [31:0] depth_in;
        logic        half_transparent;
    } t_pix_in;

    typedef struct packed {
        logic [11:0] out_x;
        logic [11:0] out_y;
        logic [23:0] packed_color;
        logic [31:0] out_depth;
    } t_pix_out;

    typedef logic [16:0] t_exp_tab [16];

    localparam t_exp_tab EXP_WHOLE = '{
        17'd65536, 17'd24109, 17'd8869, 17'd3263, 17'd1200, 17'd442, 17'd162, 17'd60,
        17'd22, 17'd8, 17'd3, 17'd1, 17'd0, 17'd0, 17'd0, 17'd0
    };
    localparam t_exp_tab EXP_SIXTEENTH = '{
        17'd65536, 17'd61565, 17'd57835, 17'd54331, 17'd51039, 17'd47947, 17'd45042,
        17'd42313, 17'd39750, 17'd37341, 17'd35079, 17'd32954, 17'd30957, 17'd29081,
        17'd27319, 17'd25664
    };
    localparam t_exp_tab EXP_FINE = '{
        17'd65536, 17'd65280, 17'd65026, 17'd64772, 17'd64520, 17'd64268, 17'd64018,
        17'd63768, 17'd63520, 17'd63272, 17'd63025, 17'd62780, 17'd62535, 17'd62291,
        17'd62048, 17'd61806
    };

    typedef logic [7:0] t_bayer [16][16];

    localparam t_bayer BAYER = '{
        '{8'd0,8'd191,8'd48,8'd239,8'd12,8'd203,8'd60,8'd251,
          8'd3,8'd194,8'd51,8'd242,8'd15,8'd206,8'd63,8'd254},
        '{8'd127,8'd64,8'd175,8'd112,8'd139,8'd76,8'd187,8'd124,
          8'd130,8'd67,8'd178,8'd115,8'd142,8'd79,8'd190,8'd127},
        '{8'd32,8'd223,8'd16,8'd207,8'd44,8'd235,8'd28,8'd219,
          8'd35,8'd226,8'd19,8'd210,8'd47,8'd238,8'd31,8'd222},
        '{8'd159,8'd96,8'd143,8'd80,8'd171,8'd108,8'd155,8'd92,
          8'd162,8'd99,8'd146,8'd83,8'd174,8'd111,8'd158,8'd95},
        '{8'd8,8'd199,8'd56,8'd247,8'd4,8'd195,8'd52,8'd243,
          8'd11,8'd202,8'd59,8'd250,8'd7,8'd198,8'd55,8'd246},
        '{8'd135,8'd72,8'd183,8'd120,8'd131,8'd68,8'd179,8'd116,
          8'd138,8'd75,8'd186,8'd123,8'd134,8'd71,8'd182,8'd119},
        '{8'd40,8'd231,8'd24,8'd215,8'd36,8'd227,8'd20,8'd211,
          8'd43,8'd234,8'd27,8'd218,8'd39,8'd230,8'd23,8'd214},
        '{8'd167,8'd104,8'd151,8'd88,8'd163,8'd100,8'd147,8'd84,
          8'd170,8'd107,8'd154,8'd91,8'd166,8'd103,8'd150,8'd87},
        '{8'd2,8'd193,8'd50,8'd241,8'd14,8'd205,8'd62,8'd253,
          8'd1,8'd192,8'd49,8'd240,8'd13,8'd204,8'd61,8'd252},
        '{8'd129,8'd66,8'd177,8'd114,8'd141,8'd78,8'd189,8'd126,
          8'd128,8'd65,8'd176,8'd113,8'd140,8'd77,8'd188,8'd125},
        '{8'd34,8'd225,8'd18,8'd209,8'd46,8'd237,8'd30,8'd221,
          8'd33,8'd224,8'd17,8'd208,8'd45,8'd236,8'd29,8'd220},
        '{8'd161,8'd98,8'd145,8'd82,8'd173,8'd110,8'd157,8'd94,
          8'd160,8'd97,8'd144,8'd81,8'd172,8'd109,8'd156,8'd93},
        '{8'd10,8'd201,8'd58,8'd249,8'd6,8'd197,8'd54,8'd245,
          8'd9,8'd200,8'd57,8'd248,8'd5,8'd196,8'd53,8'd244},
        '{8'd137,8'd74,8'd185,8'd122,8'd133,8'd70,8'd181,8'd118,
          8'd136,8'd73,8'd184,8'd121,8'd132,8'd69,8'd180,8'd117},
        '{8'd42,8'd233,8'd26,8'd217,8'd38,8'd229,8'd22,8'd213,
          8'd41,8'd232,8'd25,8'd216,8'd37,8'd228,8'd21,8'd212},
        '{8'd169,8'd106,8'd153,8'd90,8'd165,8'd102,8'd149,8'd86,
          8'd168,8'd105,8'd152,8'd89,8'd164,8'd101,8'd148,8'd85}
    };

    // Reciprocal table: entry k-1 holds ceil(2^18 / k) for k in 1..256
    typedef logic [18:0] t_recip_tab [256];

    function automatic t_recip_tab make_recip();
        t_recip_tab  tab;
        int unsigned q;
        int unsigned rm;
        for (int k = 1; k <= 256; k++) begin
            q  = 0;
            rm = 0;
            // long division of 2^18 by k, one bit per step
            for (int b = 18; b >= 0; b--) begin
                rm = (rm << 1) | ((b == 18) ? 1 : 0);
                q  = q << 1;
                if (rm >= k) begin
                    rm = rm - k;
                    q  = q | 1;
                end
            end
            if (rm != 0) begin
                q = q + 1;
            end
            tab[k-1] = q[18:0];
        end
        return tab;
    endfunction

    localparam t_recip_tab RECIP_TAB = make_recip();

endpackage

[rtl/pfdp_fog.sv]
// Fog factor pipeline: depth to Q1.15 fog factor over nine register stages.
module pfdp_fog import pfdp_pkg::*; (
    input  logic             i_clk,
    input  logic [NST-1:0]   i_en,
    input  t_cfg             i_cfg,
    input  logic [31:0]      i_d,
    output logic [15:0]      o_fog
);

    logic        r_neg1;
    logic [31:0] r_mag;
    logic        r_neg2;
    logic [47:0] r_phi;
    logic [47:0] r_plo;
    logic        r_neg3;
    logic [32:0] r_r;
    logic        r_fneg4;
    logic [33:0] r_fabs;
    logic        r_fneg5;
    logic [49:0] r_umag;
    logic        r_force6;
    logic [15:0] r_fval6;
    logic        r_sq6;
    logic [11:0] r_a6;
    logic        r_force7;
    logic [15:0] r_fval7;
    logic [11:0] r_a7;
    logic        r_force8;
    logic [15:0] r_fval8;
    logic [3:0]  r_afine8;
    logic [16:0] r_e1;
    logic [15:0] r_fog;

    logic [48:0] n_sum;
    logic [33:0] n_q;
    logic        n_force;
    logic [15:0] n_fval;
    logic        n_sq;
    logic [11:0] n_a;
    logic [19:0] n_qq;
    logic [33:0] n_p8;
    logic [33:0] n_p9;
    logic [15:0] n_e;

    // Offset depth against far plane: magnitude and sign
    always_ff @(posedge i_clk) begin
        if (i_en[ST_MAG]) begin
            r_neg1 <= i_d > i_cfg.far_depth;
            r_mag  <= (i_d > i_cfg.far_depth) ? i_d - i_cfg.far_depth
                                              : i_cfg.far_depth - i_d;
        end
    end

    // Split product with the Q0.32 reciprocal range
    always_ff @(posedge i_clk) begin
        if (i_en[ST_MUL]) begin
            r_neg2 <= r_neg1;
            r_phi  <= r_mag * i_cfg.inv_depth_range[31:16];
            r_plo  <= r_mag * i_cfg.inv_depth_range[15:0];
        end
    end

    // Combine partial products
    assign n_sum = {1'b0, r_phi} + {17'd0, r_plo[47:16]};

    always_ff @(posedge i_clk) begin
        if (i_en[ST_RECIP]) begin
            r_neg3 <= r_neg2;
            r_r    <= n_sum[48:16];
        end
    end

    // f = 1.0 -/+ r as sign and magnitude
    always_ff @(posedge i_clk) begin
        if (i_en[ST_FABS]) begin
            if (r_neg3) begin
                r_fneg4 <= 1'b0;
                r_fabs  <= {1'b0, r_r} + 34'd65536;
            end else if (r_r > 33'd65536) begin
                r_fneg4 <= 1'b1;
                r_fabs  <= {1'b0, r_r} - 34'd65536;
            end else begin
                r_fneg4 <= 1'b0;
                r_fabs  <= 34'd65536 - {1'b0, r_r};
            end
        end
    end

    // Scale by density
    always_ff @(posedge i_clk) begin
        if (i_en[ST_UMAG]) begin
            r_fneg5 <= r_fneg4;
            r_umag  <= r_fabs * i_cfg.fog_density;
        end
    end

    // Decode mode: direct results or exp argument
    always_comb begin
        n_q     = r_umag[49:16];
        n_force = 1'b1;
        n_fval  = 16'd0;
        n_sq    = 1'b0;
        n_a     = 12'd0;
        case (i_cfg.fog_mode)
            FOG_LINEAR: begin
                if (!r_fneg5) begin
                    n_fval = (r_umag[49:9] > 41'(UNIT)) ? UNIT : r_umag[24:9];
                end
            end
            FOG_EXP: begin
                if (r_fneg5 || r_umag == 50'd0) begin
                    n_fval = 16'd0;
                end else if (n_q >= 34'd4096) begin
                    n_fval = UNIT;
                end else begin
                    n_force = 1'b0;
                    n_a     = n_q[11:0];
                end
            end
            FOG_EXP2: begin
                if (n_q >= 34'd1024) begin
                    n_fval = UNIT;
                end else begin
                    n_force = 1'b0;
                    n_sq    = 1'b1;
                    n_a     = {2'd0, n_q[9:0]};
                end
            end
            default: begin
                n_fval = 16'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en[ST_DEC]) begin
            r_force6 <= n_force;
            r_fval6  <= n_fval;
            r_sq6    <= n_sq;
            r_a6     <= n_a;
        end
    end

    // Square the argument for exp-squared
    assign n_qq = r_a6[9:0] * r_a6[9:0];

    always_ff @(posedge i_clk) begin
        if (i_en[ST_ARG]) begin
            r_force7 <= r_force6;
            r_fval7  <= r_fval6;
            r_a7     <= r_sq6 ? n_qq[19:8] : r_a6;
        end
    end

    // Coarse exp product
    assign n_p8 = EXP_WHOLE[r_a7[11:8]] * EXP_SIXTEENTH[r_a7[7:4]];

    always_ff @(posedge i_clk) begin
        if (i_en[ST_E1]) begin
            r_force8 <= r_force7;
            r_fval8  <= r_fval7;
            r_afine8 <= r_a7[3:0];
            r_e1     <= n_p8[32:16];
        end
    end

    // Fine exp product and fog = 1 - exp
    assign n_p9 = r_e1 * EXP_FINE[r_afine8];
    assign n_e  = n_p9[32:17];

    always_ff @(posedge i_clk) begin
        if (i_en[ST_FOG]) begin
            if (r_force8) begin
                r_fog <= r_fval8;
            end else begin
                r_fog <= (n_e >= UNIT) ? 16'd0 : UNIT - n_e;
            end
        end
    end

    assign o_fog = r_fog;

endmodule

[rtl/pfdp_shade.sv]
// One color channel: fog blend, scale to 8 bits, ordered dither over five stages.
module pfdp_shade import pfdp_pkg::*; (
    input  logic             i_clk,
    input  logic [NST-1:0]   i_en,
    input  logic [15:0]      i_chan,
    input  logic [15:0]      i_fog_chan,
    input  logic [15:0]      i_fog,
    input  logic [3:0]       i_bx,
    input  logic [3:0]       i_by,
    input  t_dith            i_dith,
    output logic [7:0]       o_val
);

    logic [31:0] r_p1;
    logic [31:0] r_p2;
    logic [7:0]  r_bay;
    logic [15:0] r_b;
    logic [7:0]  r_corr11;
    logic [7:0]  r_v;
    logic [7:0]  r_corr12;
    logic [7:0]  r_v13;
    logic [8:0]  r_i;
    logic [7:0]  r_out;

    logic [15:0] n_c;
    logic [15:0] n_fc;
    logic [31:0] n_sum;
    logic [26:0] n_cp;
    logic [22:0] n_vp;
    logic [8:0]  n_vc;
    logic [27:0] n_tp;
    logic [9:0]  n_t;
    logic [17:0] n_ip;

    // Saturate channels to 1.0, form blend products
    assign n_c  = (i_chan > UNIT) ? UNIT : i_chan;
    assign n_fc = (i_fog_chan > UNIT) ? UNIT : i_fog_chan;

    always_ff @(posedge i_clk) begin
        if (i_en[ST_PROD]) begin
            r_p1  <= n_c * (UNIT - i_fog);
            r_p2  <= n_fc * i_fog;
            r_bay <= BAYER[i_bx][i_by];
        end
    end

    // Round the blend, threshold share per level
    assign n_sum = r_p1 + r_p2 + 32'd16384;
    assign n_cp  = r_bay * i_dith.mn;

    always_ff @(posedge i_clk) begin
        if (i_en[ST_SUM]) begin
            r_b      <= n_sum[30:15];
            r_corr11 <= n_cp[25:18];
        end
    end

    // Scale to 0..255
    assign n_vp = r_b * 23'd255;

    always_ff @(posedge i_clk) begin
        if (i_en[ST_V]) begin
            r_v      <= n_vp[22:15];
            r_corr12 <= r_corr11;
        end
    end

    // Level index, clamped to the level count
    assign n_vc = {1'b0, r_v} + {1'b0, r_corr12};
    assign n_tp = n_vc * i_dith.mdiv;
    assign n_t  = n_tp[27:18];

    always_ff @(posedge i_clk) begin
        if (i_en[ST_LVL]) begin
            r_v13 <= r_v;
            r_i   <= (n_t > {1'b0, i_dith.lv}) ? i_dith.lv : n_t[8:0];
        end
    end

    // Back to an 8-bit value, or plain truncation with dithering off
    assign n_ip = r_i * i_dith.div;

    always_ff @(posedge i_clk) begin
        if (i_en[ST_OUT]) begin
            if (i_dith.lv == 9'd0) begin
                r_out <= r_v13;
            end else begin
                r_out <= (n_ip > 18'd255) ? 8'd255 : n_ip[7:0];
            end
        end
    end

    assign o_val = r_out;

endmodule

[rtl/pixel_fog_dither_pack.sv]
// Top level: configuration registers, pipeline control and RGB888 pack.
//
// Pixel fog, checkerboard discard, ordered dither and RGB888 pack.
// Input channel: i_valid / o_stall with payload i_pix; a word is taken at
// a rising edge with i_valid high and o_stall low. Output channel: o_valid
// / i_stall with payload o_pix, taken on o_valid high and i_stall low.
// Configuration: i_cfg_we writes register i_cfg_idx with i_cfg_wdata;
// write only while the pipeline is empty.
// Throughput: one word per clock while i_stall is low; the pipeline has
// fifteen stages.
// Path: input stage, nine fog stages, then five shade stages ending in
// the output register. A half-transparent pixel with even x+y is dropped
// at the input stage and gives no output word.
// Stall: i_stall holds the output register; stages behind it fill their
// bubbles and keep accepting until every stage holds a word, then o_stall
// rises. No word is lost or repeated.
// Reset: all stages empty, configuration registers at their reset values.
module pixel_fog_dither_pack import pfdp_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [47:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_pix_in     i_pix,
    output logic        o_valid,
    input  logic        i_stall,
    output t_pix_out    o_pix
);

    localparam logic [11:0] CMASK = 12'((64'd1 << COORD_WIDTH) - 64'd1);

    t_cfg        r_cfg;
    t_dith       r_dith;
    logic [NST-1:0] r_vld;
    t_pix_in     r_pay [NST];
    logic [31:0] r_d;

    logic [NST-1:0] n_rdy;
    logic        n_keep;
    t_pix_in     n_pix;
    logic [8:0]  n_lv;
    logic [18:0] n_mn;
    logic [15:0] w_fog;
    logic [7:0]  w_red;
    logic [7:0]  w_green;
    logic [7:0]  w_blue;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fog_mode        <= FOG_NONE;
            r_cfg.fog_density     <= 16'd256;
            r_cfg.fog_start       <= 32'd0;
            r_cfg.far_depth       <= 32'd6553600;
            r_cfg.inv_depth_range <= 32'd42950000;
            r_cfg.fog_rgb         <= 48'd0;
            r_cfg.color_levels    <= 9'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FOG_MODE:     r_cfg.fog_mode        <= i_cfg_wdata[1:0];
                CFG_FOG_DENSITY:  r_cfg.fog_density     <= i_cfg_wdata[15:0];
                CFG_FOG_START:    r_cfg.fog_start       <= i_cfg_wdata[31:0];
                CFG_FAR_DEPTH:    r_cfg.far_depth       <= i_cfg_wdata[31:0];
                CFG_INV_RANGE:    r_cfg.inv_depth_range <= i_cfg_wdata[31:0];
                CFG_FOG_RGB:      r_cfg.fog_rgb         <= i_cfg_wdata;
                CFG_COLOR_LEVELS: r_cfg.color_levels    <= i_cfg_wdata[8:0];
                default: begin
                end
            endcase
        end
    end

    // Derive dither reciprocals from the level count
    assign n_lv = (r_cfg.color_levels > 9'd256) ? 9'd256 : r_cfg.color_levels;
    assign n_mn = RECIP_TAB[8'(n_lv - 9'd1)];

    always_ff @(posedge i_clk) begin
        r_dith.lv   <= n_lv;
        r_dith.mn   <= n_mn;
        r_dith.div  <= n_mn[18:10];
        r_dith.mdiv <= RECIP_TAB[8'(r_dith.div - 9'd1)];
    end

    // Per-stage ready: a stage loads when empty or when its word moves on
    always_comb begin
        n_rdy[NST-1] = !r_vld[NST-1] || !i_stall;
        for (int k = NST - 2; k >= 0; k--) begin
            n_rdy[k] = !r_vld[k] || n_rdy[k+1];
        end
    end

    assign o_stall = !n_rdy[ST_IN];

    // Drop half-transparent pixels on even squares
    assign n_keep = !(i_pix.half_transparent && !(i_pix.pixel_x[0] ^ i_pix.pixel_y[0]));

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (n_rdy[ST_IN]) begin
                r_vld[ST_IN] <= i_valid && n_keep;
            end
            for (int k = 1; k < NST; k++) begin
                if (n_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Mask coordinates to the configured width
    always_comb begin
        n_pix         = i_pix;
        n_pix.pixel_x = i_pix.pixel_x & CMASK;
        n_pix.pixel_y = i_pix.pixel_y & CMASK;
    end

    // Input stage: subtract fog start; carry the pixel along the pipeline
    always_ff @(posedge i_clk) begin
        if (n_rdy[ST_IN]) begin
            r_pay[ST_IN] <= n_pix;
            r_d <= (i_pix.depth_in > r_cfg.fog_start) ? i_pix.depth_in - r_cfg.fog_start
                                                      : 32'd0;
        end
        for (int k = 1; k < NST; k++) begin
            if (n_rdy[k]) begin
                r_pay[k] <= r_pay[k-1];
            end
        end
    end

    pfdp_fog u_fog (
        .i_clk (i_clk),
        .i_en  (n_rdy),
        .i_cfg (r_cfg),
        .i_d   (r_d),
        .o_fog (w_fog)
    );

    pfdp_shade u_red (
        .i_clk      (i_clk),
        .i_en       (n_rdy),
        .i_chan     (r_pay[ST_FOG].red_in),
        .i_fog_chan (r_cfg.fog_rgb[47:32]),
        .i_fog      (w_fog),
        .i_bx       (r_pay[ST_FOG].pixel_x[3:0]),
        .i_by       (r_pay[ST_FOG].pixel_y[3:0]),
        .i_dith     (r_dith),
        .o_val      (w_red)
    );

    pfdp_shade u_green (
        .i_clk      (i_clk),
        .i_en       (n_rdy),
        .i_chan     (r_pay[ST_FOG].green_in),
        .i_fog_chan (r_cfg.fog_rgb[31:16]),
        .i_fog      (w_fog),
        .i_bx       (r_pay[ST_FOG].pixel_x[3:0]),
        .i_by       (r_pay[ST_FOG].pixel_y[3:0]),
        .i_dith     (r_dith),
        .o_val      (w_green)
    );

    pfdp_shade u_blue (
        .i_clk      (i_clk),
        .i_en       (n_rdy),
        .i_chan     (r_pay[ST_FOG].blue_in),
        .i_fog_chan (r_cfg.fog_rgb[15:0]),
        .i_fog      (w_fog),
        .i_bx       (r_pay[ST_FOG].pixel_x[3:0]),
        .i_by       (r_pay[ST_FOG].pixel_y[3:0]),
        .i_dith     (r_dith),
        .o_val      (w_blue)
    );

    // Pack the output word
    assign o_valid            = r_vld[ST_OUT];
    assign o_pix.out_x        = r_pay[ST_OUT].pixel_x;
    assign o_pix.out_y        = r_pay[ST_OUT].pixel_y;
    assign o_pix.packed_color = {w_red, w_green, w_blue};
    assign o_pix.out_depth    = r_pay[ST_OUT].depth_in;

    // A dropped pixel never fills the input stage
    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !n_keep) |=> !r_vld[ST_IN])
        else $error("discarded pixel entered the pipeline");

    // Input stalls only when every stage holds a word
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_vld == '1))
        else $error("input stalled with a bubble in the pipeline");

    // A held output word keeps its coordinates
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(r_pay[ST_OUT].pixel_x)))
        else $error("stalled output word changed");

    // Saturated level count stays in range
    a_lv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_lv <= 9'd256)
        else $error("level count out of range");

endmodule
